@@ hw/rtl/csvt_pkg.sv @@
// Shared types and constants for the CSV field tokenizer.
// Used by every module under hw/rtl except csvt_ram; depends on nothing.
package csvt_pkg;

  localparam int MAX_FIELD_BYTES_DEF = 64;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic [7:0] DELIMITER_RST = 8'd44;
  localparam logic [7:0] QUOTE_RST     = 8'd34;
  localparam logic       DROP_BLANK_RST = 1'b1;
  localparam logic       UNQUOTE_RST    = 1'b1;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  typedef enum logic [1:0] {
    REG_DELIMITER = 2'd0,
    REG_QUOTE     = 2'd1,
    REG_DROP      = 2'd2,
    REG_UNQUOTE   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] field_byte;
    logic       has_byte;
    logic       field_end;
    logic       row_end;
    logic       input_end;
    logic       field_truncated;
    logic       last_of_run;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic store;
    logic clear_field;
    logic emit_init;
    logic rd_en;
    logic step;
    logic flush;
    logic marker;
    logic row_end;
    logic input_end;
    logic last;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic more;
    logic use_ready;
    logic out_free;
  } dp_stat_t;

endpackage

@@ hw/rtl/csvt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module csvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/csvt_dpath.sv @@
// Datapath: field buffer RAM, field length, unquote walk, hold and output registers.
// Depends on csvt_pkg and csvt_ram.
module csvt_dpath
  import csvt_pkg::*;
#(
  parameter int MAX_FIELD_BYTES = MAX_FIELD_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] text_byte,
  input  logic [7:0] quote_char,
  input  logic       unquote_fields,
  input  dp_cmd_t    cmd,
  output dp_stat_t   stat,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item
);

  localparam int LW = $clog2(MAX_FIELD_BYTES);
  localparam logic [LW-1:0] CAP = LW'(MAX_FIELD_BYTES - 1);

  logic [LW-1:0] len, len_next;
  logic          ovf, ovf_next;
  logic [7:0]    first_byte, last_byte;
  logic [LW-1:0] idx, endi;
  logic          esc, unq;
  logic          hold_valid, hold_valid_next;
  logic [7:0]    hold_byte;
  logic          out_valid_next;
  out_item_t     out_item_next;

  logic       ram_we;
  logic [7:0] rdata;
  logic       keep, out_free, push_mid, wrap_ok, clr;

  csvt_ram #(
    .WIDTH (8),
    .DEPTH (MAX_FIELD_BYTES)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (len),
    .wdata (text_byte),
    .re    (cmd.rd_en),
    .raddr (idx),
    .rdata (rdata)
  );

  // field is wrapped in quotes and not truncated
  assign wrap_ok = unquote_fields && !ovf && ({1'b0, len} >= (LW+1)'(2)) &&
                   first_byte == quote_char && last_byte == quote_char;

  assign ram_we   = cmd.store && (len != CAP);
  assign keep     = !(unq && !esc && rdata == quote_char);
  assign out_free = !out_valid || !out_stall;
  assign push_mid = cmd.step && keep && hold_valid;
  assign clr      = cmd.clear_field || cmd.flush || cmd.marker;

  assign stat.empty     = (len == '0) && !ovf;
  assign stat.more      = idx < endi;
  assign stat.use_ready = !(keep && hold_valid && !out_free);
  assign stat.out_free  = out_free;

  always_comb begin
    len_next        = len;
    ovf_next        = ovf;
    hold_valid_next = hold_valid;
    out_item_next   = out_item;
    out_valid_next  = out_valid && out_stall;
    if (cmd.store) begin
      if (len != CAP) begin
        len_next = len + LW'(1);
      end else begin
        ovf_next = 1'b1;
      end
    end
    if (cmd.step && keep) begin
      hold_valid_next = 1'b1;
    end
    if (push_mid) begin
      out_item_next  = '{field_byte: hold_byte, has_byte: 1'b1, default: 1'b0};
      out_valid_next = 1'b1;
    end
    if (cmd.flush) begin
      out_item_next.field_byte      = hold_valid ? hold_byte : 8'd0;
      out_item_next.has_byte        = hold_valid;
      out_item_next.field_end       = 1'b1;
      out_item_next.row_end         = cmd.row_end;
      out_item_next.input_end       = cmd.input_end;
      out_item_next.field_truncated = ovf;
      out_item_next.last_of_run     = cmd.last;
      out_valid_next  = 1'b1;
      hold_valid_next = 1'b0;
    end
    if (cmd.marker) begin
      out_item_next = '{input_end: 1'b1, last_of_run: 1'b1, default: '0};
      out_valid_next = 1'b1;
    end
    if (clr) begin
      len_next = '0;
      ovf_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len        <= '0;
      ovf        <= 1'b0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      len        <= len_next;
      ovf        <= ovf_next;
      hold_valid <= hold_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_item <= out_item_next;
    if (ram_we) begin
      last_byte <= text_byte;
      if (len == '0) begin
        first_byte <= text_byte;
      end
    end
    if (cmd.emit_init) begin
      unq  <= wrap_ok;
      esc  <= 1'b1;  // first inner byte always copied
      idx  <= wrap_ok ? LW'(1) : '0;
      endi <= wrap_ok ? len - LW'(1) : len;
    end
    if (cmd.step) begin
      idx <= idx + LW'(1);
      esc <= !keep;
      if (keep) begin
        hold_byte <= rdata;
      end
    end
  end

  a_len_cap : assert property (@(posedge clk) disable iff (rst)
    len <= CAP) else $error("field length beyond capacity");

  a_ovf_full : assert property (@(posedge clk) disable iff (rst)
    ovf |-> len == CAP) else $error("overflow flagged with room left");

  a_mid_flags : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.field_end |-> !out_item.row_end && !out_item.field_truncated)
    else $error("row_end or truncated outside field end");

endmodule

@@ hw/rtl/csvt_ctrl.sv @@
// Controller: CSV scan state, row bookkeeping and the emit sequencer.
// Depends on csvt_pkg.
module csvt_ctrl
  import csvt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  input  logic [7:0] delimiter_char,
  input  logic [7:0] quote_char,
  input  logic       drop_blank_rows,
  output dp_cmd_t    cmd,
  input  dp_stat_t   stat
);

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_EMIT_INIT = 6'b000010,
    ST_EMIT_RD   = 6'b000100,
    ST_EMIT_USE  = 6'b001000,
    ST_FLUSH     = 6'b010000,
    ST_MARK      = 6'b100000
  } state_t;

  typedef enum logic [3:0] {
    SM_PLAIN   = 4'b0001,
    SM_QUOTED  = 4'b0010,
    SM_QSEEN   = 4'b0100,
    SM_AFTERCR = 4'b1000
  } scan_mode_t;

  state_t     state, state_next;
  scan_mode_t scan_mode, scan_mode_next, mode_nx;
  logic       first_in_row, first_in_row_next;
  logic       row_kept, row_kept_next;
  logic       job_rowend, job_rowend_next;
  logic       job_inend, job_inend_next;
  logic       job_last, job_last_next;
  logic       then_b, then_b_next;

  logic       accept, plain, store_en, end_en, rowend;
  logic       do_a, do_b, do_marker, fir_after, rk_after, empty_after, drop_last;
  logic [7:0] b;

  assign b        = in_item.text_byte;
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // byte classification
  always_comb begin
    plain    = 1'b1;
    store_en = 1'b0;
    end_en   = 1'b0;
    rowend   = 1'b0;
    mode_nx  = scan_mode;
    unique case (scan_mode)
      SM_AFTERCR: begin
        mode_nx = SM_PLAIN;
        plain   = (b != CH_LF);
      end
      SM_QSEEN: begin
        if (b == quote_char) begin
          store_en = 1'b1;
          mode_nx  = SM_QUOTED;
          plain    = 1'b0;
        end else begin
          mode_nx = SM_PLAIN;
        end
      end
      SM_QUOTED: begin
        store_en = 1'b1;
        plain    = 1'b0;
        if (b == quote_char) begin
          mode_nx = SM_QSEEN;
        end
      end
      SM_PLAIN: ;
      default: ;
    endcase
    if (plain) begin
      if (b == delimiter_char) begin
        end_en = 1'b1;
      end else if (b == quote_char) begin
        if (stat.empty) begin
          mode_nx = SM_QUOTED;
        end
        store_en = 1'b1;
      end else if (b == CH_LF) begin
        end_en = 1'b1;
        rowend = 1'b1;
      end else if (b == CH_CR) begin
        end_en  = 1'b1;
        rowend  = 1'b1;
        mode_nx = SM_AFTERCR;
      end else begin
        store_en = 1'b1;
      end
    end
  end

  // which emissions this byte causes
  always_comb begin
    do_a        = end_en && !(rowend && first_in_row && stat.empty && drop_blank_rows);
    fir_after   = end_en ? rowend : first_in_row;
    rk_after    = row_kept || (do_a && rowend);
    empty_after = end_en || (!store_en && stat.empty);
    drop_last   = rk_after && fir_after && empty_after;
    do_b        = in_item.final_byte && !drop_last;
    do_marker   = in_item.final_byte && drop_last && !do_a;
  end

  always_comb begin
    state_next        = state;
    scan_mode_next    = scan_mode;
    first_in_row_next = first_in_row;
    row_kept_next     = row_kept;
    job_rowend_next   = job_rowend;
    job_inend_next    = job_inend;
    job_last_next     = job_last;
    then_b_next       = then_b;
    cmd               = '0;
    cmd.row_end       = job_rowend;
    cmd.input_end     = job_inend;
    cmd.last          = job_last;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.store       = store_en;
          cmd.clear_field = end_en && !do_a;
          if (in_item.final_byte) begin
            scan_mode_next    = SM_PLAIN;
            first_in_row_next = 1'b1;
            row_kept_next     = 1'b0;
          end else begin
            scan_mode_next    = mode_nx;
            first_in_row_next = fir_after;
            row_kept_next     = rk_after;
          end
          if (do_a) begin
            job_rowend_next = rowend;
            job_inend_next  = in_item.final_byte && drop_last;
            job_last_next   = !do_b;
            then_b_next     = do_b;
            state_next      = ST_EMIT_INIT;
          end else if (do_b) begin
            job_rowend_next = 1'b1;
            job_inend_next  = 1'b1;
            job_last_next   = 1'b1;
            then_b_next     = 1'b0;
            state_next      = ST_EMIT_INIT;
          end else if (do_marker) begin
            then_b_next = 1'b0;
            state_next  = ST_MARK;
          end
        end
      end
      ST_EMIT_INIT: begin
        cmd.emit_init = 1'b1;
        state_next    = ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        if (stat.more) begin
          cmd.rd_en  = 1'b1;
          state_next = ST_EMIT_USE;
        end else begin
          state_next = ST_FLUSH;
        end
      end
      ST_EMIT_USE: begin
        if (stat.use_ready) begin
          cmd.step   = 1'b1;
          state_next = ST_EMIT_RD;
        end
      end
      ST_FLUSH: begin
        if (stat.out_free) begin
          cmd.flush = 1'b1;
          if (then_b) begin
            job_rowend_next = 1'b1;
            job_inend_next  = 1'b1;
            job_last_next   = 1'b1;
            then_b_next     = 1'b0;
            state_next      = ST_EMIT_INIT;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_MARK: begin
        if (stat.out_free) begin
          cmd.marker = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      scan_mode    <= SM_PLAIN;
      first_in_row <= 1'b1;
      row_kept     <= 1'b0;
      then_b       <= 1'b0;
    end else begin
      state        <= state_next;
      scan_mode    <= scan_mode_next;
      first_in_row <= first_in_row_next;
      row_kept     <= row_kept_next;
      then_b       <= then_b_next;
    end
  end

  always_ff @(posedge clk) begin
    job_rowend <= job_rowend_next;
    job_inend  <= job_inend_next;
    job_last   <= job_last_next;
  end

  a_fin_reset : assert property (@(posedge clk) disable iff (rst)
    accept && in_item.final_byte |=> scan_mode == SM_PLAIN && first_in_row && !row_kept)
    else $error("scan state not reset after final byte");

  a_fin_emits : assert property (@(posedge clk) disable iff (rst)
    accept && in_item.final_byte |=> state != ST_IDLE)
    else $error("final byte produced no result");

  a_mark_alone : assert property (@(posedge clk) disable iff (rst)
    state == ST_MARK |-> !then_b)
    else $error("marker with a pending field");

endmodule

@@ hw/rtl/csv_field_tokenizer_top.sv @@
// Top level of the CSV field tokenizer: APB register file, controller, datapath.
// Depends on csvt_pkg, csvt_ctrl, csvt_dpath (and csvt_ram below it).
//
// Byte-serial CSV splitter. Text enters one byte per item on the in channel;
// a field is collected in a buffer RAM of MAX_FIELD_BYTES entries (first
// MAX_FIELD_BYTES-1 raw bytes kept, the rest dropped and flagged as
// truncated) and, when the field closes on the delimiter, LF, CR or CRLF
// outside an open quote, it is replayed on the out channel one byte per
// item, the last one carrying field_end/row_end. Quoted fields may be
// unwrapped with doubled quotes collapsed; blank rows may be dropped. A byte
// that only extends a field is stored without stalling the input. A byte that
// closes a field starts a replay: set-up, then a read walk of the buffer RAM
// (an address step then a decision step per byte), then a flush; the final
// byte may add one more empty field. The block takes no
// new byte while replaying, but a finished result waits in the output
// register without holding up the next byte. Registers (byte address):
// 0x0 delimiter_char, 0x4 quote_char, 0x8 drop_blank_rows,
// 0xC unquote_fields; write them only while the block is idle.
module csv_field_tokenizer_top
  import csvt_pkg::*;
#(
  parameter int MAX_FIELD_BYTES = MAX_FIELD_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // byte input
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  // field output
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [7:0] delimiter_char;
  logic [7:0] quote_char;
  logic       drop_blank_rows;
  logic       unquote_fields;
  logic       wr_en;
  reg_idx_t   reg_sel;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // register file; low address bits ignored
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter_char  <= DELIMITER_RST;
      quote_char      <= QUOTE_RST;
      drop_blank_rows <= DROP_BLANK_RST;
      unquote_fields  <= UNQUOTE_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_DELIMITER: delimiter_char  <= pwdata[7:0];
        REG_QUOTE:     quote_char      <= pwdata[7:0];
        REG_DROP:      drop_blank_rows <= pwdata[0];
        REG_UNQUOTE:   unquote_fields  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DELIMITER: prdata = {{(APB_DW-8){1'b0}}, delimiter_char};
      REG_QUOTE:     prdata = {{(APB_DW-8){1'b0}}, quote_char};
      REG_DROP:      prdata = {{(APB_DW-1){1'b0}}, drop_blank_rows};
      REG_UNQUOTE:   prdata = {{(APB_DW-1){1'b0}}, unquote_fields};
      default:       prdata = '0;
    endcase
  end

  // scan state and emit sequencing
  csvt_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_item         (in_item),
    .delimiter_char  (delimiter_char),
    .quote_char      (quote_char),
    .drop_blank_rows (drop_blank_rows),
    .cmd             (cmd),
    .stat            (stat)
  );

  // field buffer and output registers
  csvt_dpath #(
    .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .text_byte      (in_item.text_byte),
    .quote_char     (quote_char),
    .unquote_fields (unquote_fields),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item)
  );

endmodule
